>>> sv/rdmc_pkg.sv
// ============================================================================
// rdmc_pkg - shared definitions for the depth-first maze carver
// Opcodes, status codes, direction codes and field widths used by the
// sequencer and the neighbour unit.
// ============================================================================
package rdmc_pkg;

	// Default side of the wall matrix; the cell grid is half of it per side
	localparam int MATRIX_SIDE_DEF = 8;

	// Fixed field widths
	localparam int OP_W    = 2;
	localparam int IDX_W   = 4;
	localparam int DIR_W   = 2;
	localparam int STAT_W  = 2;
	localparam int WALL_W  = 4;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Response status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_CARVED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_REJECT  = 2'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

	// Directions; the same code is the wall bit position
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

	// All walls standing
	localparam logic [WALL_W-1:0] WALLS_ALL = 4'hF;

	// Wall mask for one direction
	function automatic logic [WALL_W-1:0] wall_bit(input logic [DIR_W-1:0] dir);
		wall_bit = WALL_W'(1) << dir;
	endfunction

endpackage

>>> sv/rdmc_nbr.sv
// ============================================================================
// rdmc_nbr - neighbour unit
// Steps one grid coordinate in a direction and flags moves that leave the
// grid. Shared by the carve and the backtrack phases of the sequencer.
// ============================================================================
module rdmc_nbr #(
	parameter int CELL_SIDE = rdmc_pkg::MATRIX_SIDE_DEF / 2,
	parameter int RW        = (CELL_SIDE > 1) ? $clog2(CELL_SIDE) : 1
) (
	input  logic [RW-1:0]               row,
	input  logic [RW-1:0]               col,
	input  logic [rdmc_pkg::DIR_W-1:0]  dir,
	output logic                        ok,
	output logic [RW-1:0]               nrow,
	output logic [RW-1:0]               ncol
);

	localparam logic [RW-1:0] EDGE_HI = RW'(CELL_SIDE - 1);

	// One step, bounded by the grid edges
	always_comb begin
		nrow = row;
		ncol = col;
		ok   = 1'b0;
		case (dir)
			rdmc_pkg::DIR_UP: begin
				ok   = (row != '0);
				nrow = row - RW'(1);
			end
			rdmc_pkg::DIR_DOWN: begin
				ok   = (row != EDGE_HI);
				nrow = row + RW'(1);
			end
			rdmc_pkg::DIR_RIGHT: begin
				ok   = (col != EDGE_HI);
				ncol = col + RW'(1);
			end
			default: begin
				ok   = (col != '0);
				ncol = col - RW'(1);
			end
		endcase
	end

endmodule

>>> sv/random_dfs_maze_carver_top.sv
// ============================================================================
// random_dfs_maze_carver_top - depth-first maze carver
// Recursive-backtracker maze over a square grid of cells. Cell memory holds
// walls and visited mark, a second memory holds the path stack. A one-hot
// sequencer drives the neighbour unit and both memory ports.
// ============================================================================
//
// Channel  Signals                                   Beat content
// -------  ----------------------------------------  -----------------------
// req      req_valid / req_ready                     opcode, cell_index,
//                                                    direction
// rsp      rsp_valid / rsp_ready                     status, walk_done,
//                                                    src_cell, to_cell,
//                                                    wall_bits, visited_flag
//
// One beat at a time. A step beat runs the carve states, then the backtrack,
// then the result state; the backtrack visits stack entries and probes the
// neighbours of each, one at a time through the single cell memory read
// port.
// A start beat adds a sweep that refills the cell memory, plus a coordinate
// conversion state.
// After reset the same sweep runs before req_ready rises.
// A stalled rsp channel holds the sequencer in its final state.
module random_dfs_maze_carver_top #(
	parameter int MATRIX_SIDE = rdmc_pkg::MATRIX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [rdmc_pkg::OP_W-1:0]     opcode,
	input  logic [rdmc_pkg::IDX_W-1:0]    cell_index,
	input  logic [rdmc_pkg::DIR_W-1:0]    direction,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [rdmc_pkg::STAT_W-1:0]   status,
	output logic                          walk_done,
	output logic [rdmc_pkg::IDX_W-1:0]    src_cell,
	output logic [rdmc_pkg::IDX_W-1:0]    to_cell,
	output logic [rdmc_pkg::WALL_W-1:0]   wall_bits,
	output logic                          visited_flag
);

	localparam int CELL_SIDE = MATRIX_SIDE / 2;
	localparam int NCELLS    = CELL_SIDE * CELL_SIDE;
	localparam int RW        = (CELL_SIDE > 1) ? $clog2(CELL_SIDE) : 1;
	localparam int CW        = $clog2(NCELLS);
	localparam int DW        = $clog2(NCELLS + 1);
	localparam int SW        = 2 * RW;
	localparam int XW        = (CW > rdmc_pkg::IDX_W) ? CW : rdmc_pkg::IDX_W;
	localparam int MW        = rdmc_pkg::WALL_W + 1;
	localparam logic [CW-1:0] LAST_CELL = CW'(NCELLS - 1);

	typedef enum logic [15:0] {
		S_INIT   = 16'h0001,
		S_IDLE   = 16'h0002,
		S_CLEAR  = 16'h0004,
		S_DIV    = 16'h0008,
		S_SEED   = 16'h0010,
		S_C_TOP  = 16'h0020,
		S_C_LD   = 16'h0040,
		S_C_RDN  = 16'h0080,
		S_C_CHK  = 16'h0100,
		S_C_WRC  = 16'h0200,
		S_UW     = 16'h0400,
		S_UW_LD  = 16'h0800,
		S_UW_NB  = 16'h1000,
		S_UW_CHK = 16'h2000,
		S_RD     = 16'h4000,
		S_RES    = 16'h8000
	} state_t;

	// Control state
	state_t                          state_q;
	logic [CW-1:0]                   clr_q;
	logic [DW-1:0]                   depth_q;
	logic                            active_q;
	logic                            any_vis_q;
	logic [rdmc_pkg::DIR_W-1:0]      dcnt_q;
	logic                            rsp_valid_q;

	// Datapath registers
	logic [rdmc_pkg::DIR_W-1:0]      dir_q;
	logic [rdmc_pkg::IDX_W-1:0]      rem_q;
	logic [RW-1:0]                   cur_row_q;
	logic [RW-1:0]                   cur_col_q;
	logic [RW-1:0]                   n_row_q;
	logic [RW-1:0]                   n_col_q;
	logic [CW-1:0]                   n_addr_q;
	logic [rdmc_pkg::STAT_W-1:0]     stat_w_q;
	logic [rdmc_pkg::IDX_W-1:0]      src_w_q;
	logic [rdmc_pkg::IDX_W-1:0]      to_w_q;
	logic [rdmc_pkg::WALL_W-1:0]     walls_w_q;
	logic                            vis_w_q;

	// Output register
	logic [rdmc_pkg::STAT_W-1:0]     status_q;
	logic                            walk_done_q;
	logic [rdmc_pkg::IDX_W-1:0]      src_cell_q;
	logic [rdmc_pkg::IDX_W-1:0]      to_cell_q;
	logic [rdmc_pkg::WALL_W-1:0]     wall_bits_q;
	logic                            visited_q;

	// Memories: cell = {visited, walls}, stack = {row, col}
	logic [MW-1:0]                   cell_mem [NCELLS];
	logic [SW-1:0]                   stack_mem [NCELLS];
	logic                            cm_we;
	logic [CW-1:0]                   cm_waddr;
	logic [MW-1:0]                   cm_wdata;
	logic [CW-1:0]                   cm_raddr;
	logic [MW-1:0]                   cm_rdata_q;
	logic                            st_we;
	logic [CW-1:0]                   st_waddr;
	logic [SW-1:0]                   st_wdata;
	logic [CW-1:0]                   st_raddr;
	logic [SW-1:0]                   st_rdata_q;

	// Neighbour unit and address forming
	logic [rdmc_pkg::DIR_W-1:0]      nb_dir;
	logic                            nb_ok;
	logic [RW-1:0]                   nb_row;
	logic [RW-1:0]                   nb_col;
	logic [CW-1:0]                   nb_addr;
	logic [CW-1:0]                   cur_addr;
	logic [XW-1:0]                   cur_x;
	logic [XW-1:0]                   n_x;
	logic [DW-1:0]                   depth_m1;
	logic [RW-1:0]                   seed_row;
	logic [RW-1:0]                   seed_col;
	logic                            idx_ok;
	logic                            req_acc;
	logic                            slot_free;
	logic                            stack_room;

	rdmc_nbr #(
		.CELL_SIDE (CELL_SIDE),
		.RW        (RW)
	) u_nbr (
		.row  (cur_row_q),
		.col  (cur_col_q),
		.dir  (nb_dir),
		.ok   (nb_ok),
		.nrow (nb_row),
		.ncol (nb_col)
	);

	assign nb_dir     = state_q inside {S_C_RDN} ? dir_q : dcnt_q;
	assign nb_addr    = CW'(32'(nb_row) * CELL_SIDE + 32'(nb_col));
	assign cur_addr   = CW'(32'(cur_row_q) * CELL_SIDE + 32'(cur_col_q));
	assign cur_x      = XW'(cur_addr);
	assign n_x        = XW'(n_addr_q);
	assign depth_m1   = depth_q - DW'(1);
	assign idx_ok     = (32'(cell_index) < NCELLS);
	assign req_ready  = (state_q == S_IDLE);
	assign req_acc    = req_valid && req_ready;
	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign stack_room = (32'(depth_q) < NCELLS);

	// Start cell index to row and column: compares against row boundaries
	always_comb begin
		seed_row = '0;
		seed_col = RW'(rem_q);
		for (int r = 1; r < (1 << rdmc_pkg::IDX_W); r++) begin
			if (r < CELL_SIDE && 32'(rem_q) >= r * CELL_SIDE) begin
				seed_row = RW'(r);
				seed_col = RW'(32'(rem_q) - r * CELL_SIDE);
			end
		end
	end

	// Memory port control
	always_comb begin
		cm_we    = 1'b0;
		cm_waddr = cur_addr;
		cm_wdata = {1'b0, rdmc_pkg::WALLS_ALL};
		cm_raddr = cur_addr;
		st_we    = 1'b0;
		st_waddr = depth_q[CW-1:0];
		st_wdata = {n_row_q, n_col_q};
		st_raddr = depth_m1[CW-1:0];
		case (state_q)
			S_INIT, S_CLEAR: begin
				cm_we    = 1'b1;
				cm_waddr = clr_q;
			end
			S_IDLE: begin
				cm_raddr = CW'(cell_index);
			end
			S_SEED: begin
				cm_we    = 1'b1;
				cm_wdata = {1'b1, rdmc_pkg::WALLS_ALL};
				st_we    = 1'b1;
				st_waddr = '0;
				st_wdata = {cur_row_q, cur_col_q};
			end
			S_C_RDN, S_UW_NB: begin
				cm_raddr = nb_addr;
			end
			S_C_CHK: begin
				// open the wall on the far side; read the near cell meanwhile
				cm_we    = !cm_rdata_q[MW-1];
				cm_waddr = n_addr_q;
				cm_wdata = {1'b1, cm_rdata_q[rdmc_pkg::WALL_W-1:0]
					& ~rdmc_pkg::wall_bit(dir_q ^ 2'b01)};
			end
			S_C_WRC: begin
				cm_we    = 1'b1;
				cm_wdata = {cm_rdata_q[MW-1], cm_rdata_q[rdmc_pkg::WALL_W-1:0]
					& ~rdmc_pkg::wall_bit(dir_q)};
				st_we    = stack_room;
			end
			default: begin
			end
		endcase
	end

	// Memories
	always_ff @(posedge clk) begin
		if (cm_we) begin
			cell_mem[cm_waddr] <= cm_wdata;
		end
		cm_rdata_q <= cell_mem[cm_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			stack_mem[st_waddr] <= st_wdata;
		end
		st_rdata_q <= stack_mem[st_raddr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			depth_q     <= '0;
			active_q    <= 1'b0;
			any_vis_q   <= 1'b0;
			dcnt_q      <= rdmc_pkg::DIR_UP;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_RES) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT, S_CLEAR: begin
					if (clr_q == LAST_CELL) begin
						clr_q   <= '0;
						state_q <= (state_q == S_INIT) ? S_IDLE : S_DIV;
					end else begin
						clr_q <= clr_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						if (opcode == rdmc_pkg::OP_START && idx_ok) begin
							state_q <= S_CLEAR;
						end else if (opcode == rdmc_pkg::OP_STEP && active_q) begin
							state_q <= S_C_TOP;
						end else if (opcode == rdmc_pkg::OP_READ && idx_ok) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_DIV: state_q <= S_SEED;
				S_SEED: begin
					depth_q   <= DW'(1);
					active_q  <= 1'b1;
					any_vis_q <= 1'b1;
					state_q   <= S_UW;
				end
				S_C_TOP: state_q <= S_C_LD;
				S_C_LD:  state_q <= S_C_RDN;
				S_C_RDN: state_q <= nb_ok ? S_C_CHK : S_UW;
				S_C_CHK: state_q <= cm_rdata_q[MW-1] ? S_UW : S_C_WRC;
				S_C_WRC: begin
					if (stack_room) begin
						depth_q <= depth_q + DW'(1);
					end
					state_q <= S_UW;
				end
				// backtrack: pop cells until one has an unvisited neighbour
				S_UW: begin
					if (depth_q == '0) begin
						active_q <= 1'b0;
						state_q  <= S_RES;
					end else begin
						state_q <= S_UW_LD;
					end
				end
				S_UW_LD: begin
					dcnt_q  <= rdmc_pkg::DIR_UP;
					state_q <= S_UW_NB;
				end
				S_UW_NB, S_UW_CHK: begin
					if (state_q == S_UW_NB && nb_ok) begin
						state_q <= S_UW_CHK;
					end else if (state_q == S_UW_CHK && !cm_rdata_q[MW-1]) begin
						state_q <= S_RES;
					end else if (dcnt_q == rdmc_pkg::DIR_LEFT) begin
						depth_q <= depth_m1;
						state_q <= S_UW;
					end else begin
						dcnt_q  <= dcnt_q + rdmc_pkg::DIR_W'(1);
						state_q <= S_UW_NB;
					end
				end
				S_RD: state_q <= S_RES;
				S_RES: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// Datapath and result assembly
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					dir_q     <= direction;
					rem_q     <= cell_index;
					stat_w_q  <= rdmc_pkg::ST_IGNORED;
					src_w_q   <= '0;
					to_w_q    <= '0;
					walls_w_q <= '0;
					vis_w_q   <= 1'b0;
				end
			end
			// start cell coordinates
			S_DIV: begin
				cur_row_q <= seed_row;
				cur_col_q <= seed_col;
			end
			S_SEED: stat_w_q <= rdmc_pkg::ST_OK;
			S_C_LD, S_UW_LD: begin
				cur_row_q <= st_rdata_q[SW-1:RW];
				cur_col_q <= st_rdata_q[RW-1:0];
			end
			S_C_RDN: begin
				n_row_q  <= nb_row;
				n_col_q  <= nb_col;
				n_addr_q <= nb_addr;
				if (!nb_ok) begin
					stat_w_q <= rdmc_pkg::ST_REJECT;
				end
			end
			S_C_CHK: begin
				if (cm_rdata_q[MW-1]) begin
					stat_w_q <= rdmc_pkg::ST_REJECT;
				end
			end
			S_C_WRC: begin
				stat_w_q <= rdmc_pkg::ST_CARVED;
				src_w_q  <= cur_x[rdmc_pkg::IDX_W-1:0];
				to_w_q   <= n_x[rdmc_pkg::IDX_W-1:0];
			end
			S_RD: begin
				stat_w_q  <= rdmc_pkg::ST_OK;
				walls_w_q <= cm_rdata_q[rdmc_pkg::WALL_W-1:0];
				vis_w_q   <= cm_rdata_q[MW-1];
			end
			S_RES: begin
				if (slot_free) begin
					status_q    <= stat_w_q;
					walk_done_q <= (depth_q == '0) && any_vis_q;
					src_cell_q  <= src_w_q;
					to_cell_q   <= to_w_q;
					wall_bits_q <= walls_w_q;
					visited_q   <= vis_w_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign walk_done    = walk_done_q;
	assign src_cell     = src_cell_q;
	assign to_cell      = to_cell_q;
	assign wall_bits    = wall_bits_q;
	assign visited_flag = visited_q;

	// Checks
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(depth_q) <= NCELLS)
		else $error("stack depth beyond grid size");

	a_active_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (active_q == (depth_q != '0)))
		else $error("walk flag disagrees with stack depth");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q != S_IDLE))
		else $error("accepted beat left no work");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RES))
		else $error("response raised outside result state");

	a_done_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && walk_done_q) |-> any_vis_q)
		else $error("walk done with nothing visited");

endmodule
